>>> rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store modules.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_DROP   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic take;
		logic chk;
		logic idx_init;
		logic idx_step;
		logic mem_rd;
		logic mem_wr;
		logic wr_val;
		logic cnt_inc;
		logic cnt_dec;
		logic out_load;
	} ils_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] status;
		logic       shift_done;
	} ils_sts_t;

endpackage

>>> rtl/ils_dp.sv
// ----------------------------------------------------------------------------
// ils_dp
// Datapath: request registers, entry memory, count, shift index and the
// response register.
// ----------------------------------------------------------------------------
module ils_dp #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ils_pkg::req_t     req,
	input  ils_pkg::ils_cmd_t cmd,
	output ils_pkg::ils_sts_t sts,
	output ils_pkg::rsp_t     rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	logic [31:0]   mem [DEPTH];
	logic [2:0]    cmd_q;
	logic [4:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rdata_q;
	logic [1:0]    st_q;
	ils_pkg::rsp_t rsp_q;

	logic [1:0]    status;
	logic          full;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] idx_x;
	logic [CW:0]   idx_inc;
	logic [CW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          shift_done;

	assign pos_x   = CMPW'(pos_q);
	assign cnt_x   = CMPW'(count_q);
	assign idx_x   = CMPW'(idx_q);
	assign full    = (count_q == CW'(DEPTH));
	assign idx_inc = {1'b0, idx_q} + (CW + 1)'(1);

	always_comb begin
		unique case (cmd_q)
			ils_pkg::CMD_APPEND: status = full ? ils_pkg::ST_FULL : ils_pkg::ST_OK;
			ils_pkg::CMD_INSERT: begin
				if (full)
					status = ils_pkg::ST_FULL;
				else if (pos_x > cnt_x)
					status = ils_pkg::ST_RANGE;
				else
					status = ils_pkg::ST_OK;
			end
			ils_pkg::CMD_DELETE, ils_pkg::CMD_READ:
				status = (pos_x >= cnt_x) ? ils_pkg::ST_RANGE : ils_pkg::ST_OK;
			ils_pkg::CMD_DROP:
				status = (count_q == '0) ? ils_pkg::ST_EMPTY : ils_pkg::ST_OK;
			default: status = ils_pkg::ST_RANGE;
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			ils_pkg::CMD_APPEND: shift_done = 1'b1;
			ils_pkg::CMD_INSERT: shift_done = (idx_x == pos_x);
			ils_pkg::CMD_DELETE: shift_done = (idx_inc == {1'b0, count_q});
			default:             shift_done = 1'b1;
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			ils_pkg::CMD_INSERT: rd_idx = idx_q - CW'(1);
			ils_pkg::CMD_DELETE: rd_idx = idx_inc[CW-1:0];
			default:             rd_idx = CW'(pos_q);
		endcase
	end

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_addr = idx_q[AW-1:0];

	assign sts.command    = cmd_q;
	assign sts.status     = status;
	assign sts.shift_done = shift_done;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= req.command;
			pos_q <= req.position;
			val_q <= req.value;
		end
		if (cmd.chk)
			st_q <= status;
		if (cmd.idx_init)
			idx_q <= (cmd_q == ils_pkg::CMD_DELETE) ? CW'(pos_q) : count_q;
		else if (cmd.idx_step)
			idx_q <= (cmd_q == ils_pkg::CMD_DELETE) ? idx_inc[CW-1:0] : idx_q - CW'(1);
		if (cmd.mem_wr)
			mem[wr_addr] <= cmd.wr_val ? val_q : rdata_q;
		if (cmd.mem_rd)
			rdata_q <= mem[rd_addr];
		if (cmd.out_load) begin
			rsp_q.read_value  <= (cmd_q == ils_pkg::CMD_READ && st_q == ils_pkg::ST_OK)
				? rdata_q : 32'sd0;
			rsp_q.status      <= st_q;
			rsp_q.entry_count <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Controller: handshakes and the sequence of datapath commands per request.
// ----------------------------------------------------------------------------
module ils_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  ils_pkg::ils_sts_t sts,
	output ils_pkg::ils_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_INSW = 3'd3;
	localparam logic [2:0] S_DEL  = 3'd4;
	localparam logic [2:0] S_DELW = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.chk = 1'b1;
				state_d = S_DONE;
				if (sts.status == ils_pkg::ST_OK) begin
					unique case (sts.command)
						ils_pkg::CMD_APPEND, ils_pkg::CMD_INSERT: begin
							cmd.idx_init = 1'b1;
							state_d      = S_INS;
						end
						ils_pkg::CMD_DELETE: begin
							cmd.idx_init = 1'b1;
							state_d      = S_DEL;
						end
						ils_pkg::CMD_DROP: cmd.cnt_dec = 1'b1;
						ils_pkg::CMD_READ: cmd.mem_rd = 1'b1;
						default: ;
					endcase
				end
			end
			S_INS: begin
				if (sts.shift_done) begin
					cmd.mem_wr  = 1'b1;
					cmd.wr_val  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_INSW;
				end
			end
			S_INSW: begin
				cmd.mem_wr   = 1'b1;
				cmd.idx_step = 1'b1;
				state_d      = S_INS;
			end
			S_DEL: begin
				if (sts.shift_done) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_DELW;
				end
			end
			S_DELW: begin
				cmd.mem_wr   = 1'b1;
				cmd.idx_step = 1'b1;
				state_d      = S_DEL;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/indexed_list_store.sv
// Sequence from acceptance to response valid: the request is taken in IDLE and checked
// in EXEC; append and insert then shift entries in INS/INSW, delete in DEL/DELW, and
// the response is loaded in DONE. Each shifted entry needs a memory read and a write.
// One request at a time: the next is taken the cycle after the response is loaded.
// The response register lets a new request start while a response waits.
// arst_n clears the entry count and control state; entries are unknown until written.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values with append, insert, delete, drop tail
// and read by position; one response beat per request beat.
// ----------------------------------------------------------------------------
module indexed_list_store #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ils_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ils_pkg::rsp_t rsp
);

	ils_pkg::ils_cmd_t cmd;
	ils_pkg::ils_sts_t sts;

	ils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ils_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

>>> rtl/ils_chk.sv
// ----------------------------------------------------------------------------
// ils_chk
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_chk #(
	parameter int DEPTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ils_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ils_pkg::ST_OK |-> rsp.read_value == 32'sd0)
		else $error("failed command returned nonzero read value");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ils_pkg::ST_FULL |-> rsp.entry_count == 5'(DEPTH))
		else $error("full status with count below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ils_pkg::ST_EMPTY |-> rsp.entry_count == 5'd0)
		else $error("empty status with nonzero count");

endmodule

bind indexed_list_store ils_chk #(.DEPTH(DEPTH)) u_ils_chk (.*);
